FILE: design/bcvf_pkg.sv
package bcvf_pkg;

    // Time and duration format: unsigned integer ticks
    localparam int TIME_W = 32;
    typedef logic [TIME_W-1:0] tick_t;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int CHAN_OUT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_CHANNELS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_IS_CORE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_BUFFERING   = 2'd3;

    // Request operation codes
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_CONTROL = 1'b1;

    // Classified request as it travels through the queue
    typedef struct packed {
        logic  operation;
        tick_t arrival_time;
        tick_t burst_length;
        logic  fallback_ok;   // edge buffering may place an unplaced data burst
    } bcvf_req_t;

    // One channel's timing record
    typedef struct packed {
        tick_t horizon;
        tick_t void_begin;
        tick_t void_finish;
    } bcvf_row_t;

    // Saturating tick addition
    function automatic tick_t sat_add(input tick_t a, input tick_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

FILE: design/bcvf_ifs.sv
// Request channel
interface bcvf_req_if import bcvf_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  operation;
    tick_t arrival_time;
    tick_t burst_length;

    modport source (output valid, output operation, output arrival_time,
                    output burst_length, input ready);
    modport sink   (input valid, input operation, input arrival_time,
                    input burst_length, output ready);
endinterface

// Result channel
interface bcvf_res_if import bcvf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [CHAN_OUT_W-1:0] channel;
    tick_t                 start_time;

    modport source (output valid, output found, output channel,
                    output start_time, input ready);
    modport sink   (input valid, input found, input channel,
                    input start_time, output ready);
endinterface

// Configuration write channel
interface bcvf_cfg_if import bcvf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/bcvf_front.sv
module bcvf_front import bcvf_pkg::*; #(
    parameter int CHANNELS = 16,
    localparam int CNT_W   = $clog2(CHANNELS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    bcvf_cfg_if.sink         cfg,
    bcvf_req_if.sink         req,
    input  logic             q_full,
    output logic             q_push,
    output bcvf_req_t        q_req,
    output logic [CNT_W-1:0] q_first,
    output logic [CNT_W-1:0] q_stop
);

    localparam int WK_W = ((CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W) + 1;

    logic [CFG_DATA_W-1:0] ncc_reg;
    logic [CFG_DATA_W-1:0] ndc_reg;
    logic                  core_reg;
    logic                  buf_reg;

    logic [WK_W-1:0] ch_w;
    logic [WK_W-1:0] ncc_w;
    logic [WK_W-1:0] ndc_w;
    logic [WK_W-1:0] ncc_c;
    logic [WK_W-1:0] rem_c;
    logic [WK_W-1:0] ndc_c;
    logic [WK_W-1:0] last_c;

    // Configuration registers, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncc_reg  <= CFG_DATA_W'(1);
            ndc_reg  <= CFG_DATA_W'(15);
            core_reg <= 1'b1;
            buf_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CONTROL_CHANNELS: ncc_reg  <= cfg.data;
                REG_DATA_CHANNELS:    ndc_reg  <= cfg.data;
                REG_NODE_IS_CORE:     core_reg <= cfg.data[0];
                REG_EDGE_BUFFERING:   buf_reg  <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Clamp channel counts to the channels that exist
    always_comb
    begin
        ch_w   = WK_W'(CHANNELS);
        ncc_w  = WK_W'(ncc_reg);
        ndc_w  = WK_W'(ndc_reg);
        ncc_c  = (ncc_w > ch_w) ? ch_w : ncc_w;
        rem_c  = ch_w - ncc_c;
        ndc_c  = (ndc_w > rem_c) ? rem_c : ndc_w;
        last_c = ncc_c + ndc_c;
    end

    // Classify: scan range by operation, fallback eligibility
    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    always_comb
    begin
        q_req.operation    = req.operation;
        q_req.arrival_time = req.arrival_time;
        q_req.burst_length = req.burst_length;
        q_req.fallback_ok  = !core_reg && buf_reg && (ndc_c != '0);
        if (req.operation == OP_CONTROL)
        begin
            q_first = '0;
            q_stop  = CNT_W'(ncc_c);
        end
        else
        begin
            q_first = CNT_W'(ncc_c);
            q_stop  = CNT_W'(last_c);
        end
    end

endmodule

FILE: design/bcvf_queue.sv
module bcvf_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output logic [W-1:0] dout
);

    localparam int DEPTH = 2;

    logic [W-1:0] entries_reg [DEPTH];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full      = (count_reg == 2'(DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign dout      = entries_reg[rd_ptr_reg];

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= din;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("queue read while empty");

endmodule

FILE: design/bcvf_back.sv
module bcvf_back import bcvf_pkg::*; #(
    parameter int CHANNELS = 16,
    localparam int CNT_W   = $clog2(CHANNELS + 1),
    localparam int IDX_W   = $clog2(CHANNELS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  bcvf_req_t        q_req,
    input  logic [CNT_W-1:0] q_first,
    input  logic [CNT_W-1:0] q_stop,
    output logic             q_pop,
    bcvf_res_if.source       res
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE} state_t;

    // Channel table: one read port for the scan, one write at the decision
    bcvf_row_t mem [CHANNELS];
    bcvf_row_t rd_row_reg;

    state_t                state_reg,     state_next;
    bcvf_req_t             item_reg,      item_next;
    logic [CNT_W-1:0]      issue_reg,     issue_next;
    logic [CNT_W-1:0]      stop_reg,      stop_next;
    logic                  eval_vld_reg,  eval_vld_next;
    logic [IDX_W-1:0]      eval_idx_reg,  eval_idx_next;
    logic                  rd_ok_reg;
    logic [CHANNELS-1:0]   row_valid_reg, row_valid_next;
    logic                  have_reg,      have_next;
    tick_t                 gap_reg,       gap_next;
    logic [IDX_W-1:0]      best_idx_reg,  best_idx_next;
    bcvf_row_t             best_row_reg,  best_row_next;
    logic                  min_seen_reg,  min_seen_next;
    logic [IDX_W-1:0]      min_idx_reg,   min_idx_next;
    bcvf_row_t             min_row_reg,   min_row_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  res_found_reg, res_found_next;
    logic [CHAN_OUT_W-1:0] res_chan_reg,  res_chan_next;
    tick_t                 res_start_reg, res_start_next;

    logic [IDX_W-1:0] rd_addr;
    bcvf_row_t        cur_row;
    tick_t            t_arr;
    tick_t            g_void;
    tick_t            g_hor;
    logic             void_ok;
    logic             take_void;
    logic             have1;
    tick_t            gap1;
    logic             take_hor;

    logic             found;
    logic [IDX_W-1:0] sel_idx;
    bcvf_row_t        sel_row;
    tick_t            start;
    tick_t            end_time;
    bcvf_row_t        new_row;
    logic             emit_ok;
    logic             mem_wr;

    assign rd_addr = issue_reg[IDX_W-1:0];
    assign cur_row = rd_ok_reg ? rd_row_reg : '0;
    assign t_arr   = item_reg.arrival_time;

    // Per-channel evaluation: void first, then the horizon
    always_comb
    begin
        g_void    = t_arr - cur_row.void_begin;
        g_hor     = t_arr - cur_row.horizon;
        void_ok   = (item_reg.operation == OP_DATA)
                    && (t_arr >= cur_row.void_begin)
                    && (cur_row.void_finish >= t_arr)
                    && ((cur_row.void_finish - t_arr) >= item_reg.burst_length);
        take_void = void_ok && (!have_reg || (g_void < gap_reg));
        have1     = have_reg || take_void;
        gap1      = take_void ? g_void : gap_reg;
        take_hor  = (t_arr >= cur_row.horizon) && (!have1 || (g_hor < gap1));
    end

    // Decision and record update
    always_comb
    begin
        found    = have_reg || (item_reg.fallback_ok && (item_reg.operation == OP_DATA));
        sel_idx  = have_reg ? best_idx_reg : min_idx_reg;
        sel_row  = have_reg ? best_row_reg : min_row_reg;
        start    = have_reg ? t_arr : min_row_reg.horizon;
        end_time = sat_add(start, item_reg.burst_length);
        new_row  = sel_row;
        if (item_reg.operation == OP_CONTROL)
            new_row.horizon = end_time;
        else if (start == sel_row.horizon)
            new_row.horizon = end_time;
        else if (start > sel_row.horizon)
        begin
            new_row.void_begin  = sel_row.horizon;
            new_row.horizon     = end_time;
            new_row.void_finish = start;
        end
        else
            new_row.void_begin = end_time;
    end

    assign emit_ok = !out_valid_reg || res.ready;
    assign mem_wr  = (state_reg == ST_DECIDE) && emit_ok && found;
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        issue_next     = issue_reg;
        stop_next      = stop_reg;
        eval_vld_next  = 1'b0;
        eval_idx_next  = eval_idx_reg;
        row_valid_next = row_valid_reg;
        have_next      = have_reg;
        gap_next       = gap_reg;
        best_idx_next  = best_idx_reg;
        best_row_next  = best_row_reg;
        min_seen_next  = min_seen_reg;
        min_idx_next   = min_idx_reg;
        min_row_next   = min_row_reg;
        out_valid_next = out_valid_reg && !res.ready;
        res_found_next = res_found_reg;
        res_chan_next  = res_chan_reg;
        res_start_next = res_start_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_next     = q_req;
                    issue_next    = q_first;
                    stop_next     = q_stop;
                    have_next     = 1'b0;
                    min_seen_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one channel read per cycle
                if (issue_reg < stop_reg)
                begin
                    eval_vld_next = 1'b1;
                    eval_idx_next = rd_addr;
                    issue_next    = issue_reg + CNT_W'(1);
                end
                // Evaluate the channel read in the previous cycle
                if (eval_vld_reg)
                begin
                    if (take_hor)
                    begin
                        have_next     = 1'b1;
                        gap_next      = g_hor;
                        best_idx_next = eval_idx_reg;
                        best_row_next = cur_row;
                    end
                    else if (take_void)
                    begin
                        have_next     = 1'b1;
                        gap_next      = g_void;
                        best_idx_next = eval_idx_reg;
                        best_row_next = cur_row;
                    end
                    if (!min_seen_reg || (cur_row.horizon < min_row_reg.horizon))
                    begin
                        min_seen_next = 1'b1;
                        min_idx_next  = eval_idx_reg;
                        min_row_next  = cur_row;
                    end
                end
                // All reads issued; the last one is evaluated in this cycle
                if (!(issue_reg < stop_reg))
                    state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    res_found_next = found;
                    res_chan_next  = found ? CHAN_OUT_W'(sel_idx) : '0;
                    res_start_next = found ? start : '0;
                    if (found)
                        row_valid_next[sel_idx] = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            issue_reg     <= '0;
            stop_reg      <= '0;
            eval_vld_reg  <= 1'b0;
            eval_idx_reg  <= '0;
            rd_ok_reg     <= 1'b0;
            row_valid_reg <= '0;
            have_reg      <= 1'b0;
            gap_reg       <= '0;
            best_idx_reg  <= '0;
            best_row_reg  <= '0;
            min_seen_reg  <= 1'b0;
            min_idx_reg   <= '0;
            min_row_reg   <= '0;
            out_valid_reg <= 1'b0;
            res_found_reg <= 1'b0;
            res_chan_reg  <= '0;
            res_start_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            issue_reg     <= issue_next;
            stop_reg      <= stop_next;
            eval_vld_reg  <= eval_vld_next;
            eval_idx_reg  <= eval_idx_next;
            rd_ok_reg     <= row_valid_reg[rd_addr];
            row_valid_reg <= row_valid_next;
            have_reg      <= have_next;
            gap_reg       <= gap_next;
            best_idx_reg  <= best_idx_next;
            best_row_reg  <= best_row_next;
            min_seen_reg  <= min_seen_next;
            min_idx_reg   <= min_idx_next;
            min_row_reg   <= min_row_next;
            out_valid_reg <= out_valid_next;
            res_found_reg <= res_found_next;
            res_chan_reg  <= res_chan_next;
            res_start_reg <= res_start_next;
        end
    end

    // Channel table storage
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[sel_idx] <= new_row;
        rd_row_reg <= mem[rd_addr];
    end

    assign res.valid      = out_valid_reg;
    assign res.found      = res_found_reg;
    assign res.channel    = res_chan_reg;
    assign res.start_time = res_start_reg;

    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        eval_vld_reg |-> (state_reg == ST_SCAN))
        else $error("channel evaluated outside the scan");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> (CNT_W'(sel_idx) < CNT_W'(CHANNELS)))
        else $error("channel table written beyond the channel count");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_found_reg) |-> (res_chan_reg == '0 && res_start_reg == '0))
        else $error("dropped result carries channel or start time");

    a_fallback_has_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && !have_reg && found) |-> min_seen_reg)
        else $error("buffered burst placed without an earliest horizon");

endmodule

FILE: design/burst_channel_void_filling_scheduler.sv
// Burst channel scheduler, latest available unused channel with void filling.
// Each request transaction gets exactly one result transaction. A request
// scans only the channels of its kind (control channels for a control
// packet, data channels for a data burst) through the channel table's single
// read port, one channel per cycle. An item is handled in steps: the request
// is picked from the queue, its channels are read one by one, the last read
// lands, and, once the result register is free, the block decides, updates
// the table and loads the result register. The request queue holds two
// transactions and the result register one, so the request side keeps
// accepting while a result waits, until the queue is full. All timing records
// read as zero after reset; no clearing pass is needed.
module burst_channel_void_filling_scheduler import bcvf_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    bcvf_cfg_if.sink   cfg,
    bcvf_req_if.sink   req,
    bcvf_res_if.source res
);

    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int Q_W   = $bits(bcvf_req_t) + 2 * CNT_W;

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_not_empty;
    bcvf_req_t        f_req;
    logic [CNT_W-1:0] f_first;
    logic [CNT_W-1:0] f_stop;
    logic [Q_W-1:0]   q_din;
    logic [Q_W-1:0]   q_dout;
    bcvf_req_t        b_req;
    logic [CNT_W-1:0] b_first;
    logic [CNT_W-1:0] b_stop;

    // Front: configuration and request classification
    bcvf_front #(.CHANNELS(CHANNELS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_req   (f_req),
        .q_first (f_first),
        .q_stop  (f_stop)
    );

    assign q_din = {f_req, f_first, f_stop};

    // Decoupling queue
    bcvf_queue #(.W(Q_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .dout      (q_dout)
    );

    assign {b_req, b_first, b_stop} = q_dout;

    // Back: channel scan, decision, table update
    bcvf_back #(.CHANNELS(CHANNELS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_req   (b_req),
        .q_first (b_first),
        .q_stop  (b_stop),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bcvf_pkg::*;

    localparam int NUM_CHANNELS   = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 125;

    // One scheduling decision as it leaves the block
    typedef struct packed {
        logic                  found;
        logic [CHAN_OUT_W-1:0] channel;
        tick_t                 start_time;
    } assignment_t;

    logic clk;
    logic rst_n;

    bcvf_cfg_if cfg ();
    bcvf_req_if req ();
    bcvf_res_if res ();

    burst_channel_void_filling_scheduler #(
        .CHANNELS (NUM_CHANNELS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );

    // Channel timing table and register copy kept by the testbench
    tick_t       chan_horizon     [NUM_CHANNELS];
    tick_t       chan_void_begin  [NUM_CHANNELS];
    tick_t       chan_void_finish [NUM_CHANNELS];
    logic [3:0]  ctl_channels_cfg;
    logic [3:0]  dat_channels_cfg;
    logic        core_node_cfg;
    logic        buffering_cfg;

    assignment_t pending_assignments [$];
    int          error_count;
    int          idle_cycles;
    int          send_gap_max;
    int          stall_max;
    bit          hold_request;
    tick_t       time_base;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic tick_t add_sat(input tick_t a, input tick_t b);
        tick_t s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    // Work out the channel assignment for one request and update the table
    function automatic assignment_t predict_assignment(input logic op, input tick_t t,
                                                       input tick_t dur);
        int unsigned n_ctl;
        int unsigned n_dat;
        int unsigned last;
        int unsigned best;
        tick_t       gap;
        tick_t       start;
        bit          have;
        assignment_t a;
        n_ctl = ctl_channels_cfg;
        if (n_ctl > NUM_CHANNELS)
            n_ctl = NUM_CHANNELS;
        n_dat = dat_channels_cfg;
        if (n_dat > NUM_CHANNELS - n_ctl)
            n_dat = NUM_CHANNELS - n_ctl;
        last  = n_ctl + n_dat;
        best  = 0;
        gap   = '0;
        start = t;
        have  = 1'b0;
        if (op == OP_CONTROL)
        begin
            // latest control horizon not after the arrival
            for (int unsigned i = 0; i < n_ctl; i++)
            begin
                if (t >= chan_horizon[i] && (!have || t - chan_horizon[i] < gap))
                begin
                    gap  = t - chan_horizon[i];
                    best = i;
                    have = 1'b1;
                end
            end
            if (have)
                chan_horizon[best] = add_sat(t, dur);
        end
        else
        begin
            // smallest gap over voids and horizons, lowest index on ties
            for (int unsigned i = n_ctl; i < last; i++)
            begin
                if (t >= chan_void_begin[i] && chan_void_finish[i] >= t &&
                    chan_void_finish[i] - t >= dur &&
                    (!have || t - chan_void_begin[i] < gap))
                begin
                    gap  = t - chan_void_begin[i];
                    best = i;
                    have = 1'b1;
                end
                if (t >= chan_horizon[i] && (!have || t - chan_horizon[i] < gap))
                begin
                    gap  = t - chan_horizon[i];
                    best = i;
                    have = 1'b1;
                end
            end
            // edge node buffering: earliest data horizon
            if (!have && !core_node_cfg && buffering_cfg && n_dat > 0)
            begin
                best  = n_ctl;
                start = chan_horizon[n_ctl];
                for (int unsigned i = n_ctl + 1; i < last; i++)
                begin
                    if (chan_horizon[i] < start)
                    begin
                        start = chan_horizon[i];
                        best  = i;
                    end
                end
                have = 1'b1;
            end
            if (have)
            begin
                if (start == chan_horizon[best])
                    chan_horizon[best] = add_sat(start, dur);
                else if (start > chan_horizon[best])
                begin
                    chan_void_begin[best]  = chan_horizon[best];
                    chan_horizon[best]     = add_sat(start, dur);
                    chan_void_finish[best] = start;
                end
                else
                    chan_void_begin[best] = add_sat(start, dur);
            end
        end
        a.found      = have;
        a.channel    = have ? best[CHAN_OUT_W-1:0] : '0;
        a.start_time = have ? start : '0;
        return a;
    endfunction

    // Result checker: each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        assignment_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_assignments.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual found %0b ch %0d start %0h",
                         $time, res.found, res.channel, res.start_time);
            end
            else
            begin
                want = pending_assignments.pop_front();
                if (res.found !== want.found)
                begin
                    error_count++;
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, want.found, res.found);
                end
                if (res.channel !== want.channel)
                begin
                    error_count++;
                    $display("%0t: channel mismatch: expected %0d, actual %0d",
                             $time, want.channel, res.channel);
                end
                if (res.start_time !== want.start_time)
                begin
                    error_count++;
                    $display("%0t: start_time mismatch: expected %0h, actual %0h",
                             $time, want.start_time, res.start_time);
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        res.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res.ready && res.valid)
                stall_left = $urandom_range(0, stall_max);
            if (hold_request)
            begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (!rst_n)
                res.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                res.ready <= 1'b0;
                stall_left--;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // Watchdog: cycles in which no transaction moves on any channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Send one request; called at a rising edge, returns at its accepting edge
    task automatic send_request(input logic op, input tick_t t, input tick_t dur);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.operation    <= op;
        req.arrival_time <= t;
        req.burst_length <= dur;
        do
            @(posedge clk);
        while (!req.ready);
        pending_assignments.push_back(predict_assignment(op, t, dur));
    endtask

    // Wait until every expected result has come back
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            REG_CONTROL_CHANNELS: ctl_channels_cfg = value;
            REG_DATA_CHANNELS:    dat_channels_cfg = value;
            REG_NODE_IS_CORE:     core_node_cfg    = value[0];
            REG_EDGE_BUFFERING:   buffering_cfg    = value[0];
            default: ;
        endcase
    endtask

    task automatic set_channel_plan(input logic [3:0] n_ctl, input logic [3:0] n_dat,
                                    input logic core, input logic buffering);
        wait_drained();
        write_register(REG_CONTROL_CHANNELS, n_ctl);
        write_register(REG_DATA_CHANNELS, n_dat);
        write_register(REG_NODE_IS_CORE, {3'b000, core});
        write_register(REG_EDGE_BUFFERING, {3'b000, buffering});
        cfg.valid <= 1'b0;
    endtask

    // Random request, mostly aimed near existing horizons and voids
    task automatic send_random_request();
        logic        op;
        tick_t       t;
        tick_t       dur;
        tick_t       base;
        int unsigned pick;
        int unsigned ch;
        op   = ($urandom_range(0, 99) < 30) ? OP_CONTROL : OP_DATA;
        ch   = $urandom_range(0, NUM_CHANNELS - 1);
        case ($urandom_range(0, 2))
            0:       base = chan_horizon[ch];
            1:       base = chan_void_begin[ch];
            default: base = chan_void_finish[ch];
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 70)
            t = (base >= 20) ? base - 20 + $urandom_range(0, 60) : base + $urandom_range(0, 60);
        else if (pick < 94)
        begin
            time_base = time_base + $urandom_range(0, 200);
            t         = time_base + $urandom_range(0, 100);
        end
        else if (pick < 98)
            t = $urandom();
        else
            t = 32'hFFFF_FFFF - $urandom_range(0, 64);
        pick = $urandom_range(0, 99);
        if (pick < 62)
            dur = $urandom_range(0, 40);
        else if (pick < 96)
            dur = $urandom_range(0, 2000);
        else if (pick < 98)
            dur = $urandom();
        else
            dur = $urandom_range(0, 1) ? '1 : '0;
        send_request(op, t, dur);
    endtask

    // Reset settings: extremes of the fields, voids, saturation
    task automatic test_default_schedule();
        send_request(OP_CONTROL, 32'd0, 32'd0);
        send_request(OP_CONTROL, 32'd100, 32'd50);
        send_request(OP_CONTROL, 32'd120, 32'd10);    // before the horizon: dropped
        send_request(OP_DATA, 32'd0, 32'd1);
        send_request(OP_DATA, 32'd1000, 32'd100);     // opens a void
        send_request(OP_DATA, 32'd200, 32'd100);      // fills the void
        send_request(OP_DATA, 32'd300, 32'd0);        // zero length
        send_request(OP_DATA, 32'd500, 32'd600);      // too long for the void
        send_request(OP_CONTROL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_DATA, 32'hFFFF_FF00, 32'h0000_0200);
    endtask

    // Edge node: unplaced burst buffered, then dropped without buffering or on a core node
    task automatic test_edge_buffering();
        set_channel_plan(4'd1, 4'd2, 1'b0, 1'b1);
        send_request(OP_DATA, 32'd0, 32'd10);
        send_request(OP_DATA, 32'd0, 32'd10);
        set_channel_plan(4'd1, 4'd2, 1'b0, 1'b0);
        send_request(OP_DATA, 32'd0, 32'd10);
        set_channel_plan(4'd1, 4'd2, 1'b1, 1'b1);
        send_request(OP_DATA, 32'd0, 32'd10);
    endtask

    // Empty and oversubscribed channel plans
    task automatic test_channel_limits();
        set_channel_plan(4'd0, 4'd3, 1'b1, 1'b0);
        send_request(OP_CONTROL, 32'd5000, 32'd10);
        set_channel_plan(4'd2, 4'd0, 1'b0, 1'b1);
        send_request(OP_DATA, 32'd0, 32'd10);
        set_channel_plan(4'd15, 4'd15, 1'b0, 1'b1);
        send_request(OP_DATA, 32'd20000, 32'd10);
        send_request(OP_CONTROL, 32'd20000, 32'd10);
        send_request(OP_DATA, 32'd0, 32'd1);
    endtask

    // Receiver holds off while requests keep coming
    task automatic test_backpressure();
        set_channel_plan(4'd2, 4'd6, 1'b0, 1'b1);
        send_gap_max = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++)
            send_random_request();
        send_gap_max = 6;
    endtask

    // Random phases over several channel plans
    task automatic test_random_phases();
        logic [3:0] n_ctl;
        logic [3:0] n_dat;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_channel_plan(4'd1, 4'd15, 1'b1, 1'b0);
                1: set_channel_plan(4'd15, 4'd15, 1'b0, 1'b1);
                2: set_channel_plan(4'd3, 4'd4, 1'b0, 1'b1);
                3: set_channel_plan(4'd0, 4'd8, 1'b0, 1'b0);
                4: set_channel_plan(4'd2, 4'd1, 1'b0, 1'b1);
                default:
                begin
                    n_ctl = $urandom_range(0, 1) ? 4'($urandom_range(0, 4))
                                                 : 4'($urandom_range(0, 15));
                    n_dat = $urandom_range(0, 1) ? 4'($urandom_range(1, 5))
                                                 : 4'($urandom_range(0, 15));
                    set_channel_plan(n_ctl, n_dat, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)));
                end
            endcase
            // every fourth phase runs with no idling on either side
            send_gap_max = (phase % 4 == 3) ? 0 : 6;
            stall_max    = (phase % 4 == 3) ? 0 : 6;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_request();
        end
        send_gap_max = 6;
        stall_max    = 6;
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            chan_horizon[i]     = '0;
            chan_void_begin[i]  = '0;
            chan_void_finish[i] = '0;
        end
        ctl_channels_cfg = 4'd1;
        dat_channels_cfg = 4'd15;
        core_node_cfg    = 1'b1;
        buffering_cfg    = 1'b0;
        error_count      = 0;
        idle_cycles      = 0;
        send_gap_max     = 6;
        stall_max        = 6;
        hold_request     = 1'b0;
        time_base        = 32'd10000;

        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.operation    = OP_DATA;
        req.arrival_time = '0;
        req.burst_length = '0;
        cfg.valid        = 1'b0;
        cfg.index        = REG_CONTROL_CHANNELS;
        cfg.data         = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_schedule();
        test_edge_buffering();
        test_channel_limits();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
